[hw/rtl/fprm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprm_pkg
// Shared types, widths and constants of the frame pacer with rate meter.
// ----------------------------------------------------------------------------
package fprm_pkg;

	// Sliding window of record timestamps
	localparam int WINDOW = 120;
	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(WINDOW);
	localparam logic [CNT_W-1:0] WINDOW_LAST_CNT = CNT_W'(WINDOW - 1);

	// Payload widths
	localparam int TIME_W     = 32;
	localparam int FPS_W      = 21;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	// Arithmetic constants
	localparam int MS_PER_S   = 1000;
	localparam int RATE_SCALE = 20000 * (WINDOW - 1);
	localparam int NUM_W      = $clog2(RATE_SCALE + 1);
	localparam int STEP_W     = (NUM_W > 1) ? $clog2(NUM_W) : 1;
	localparam logic [FPS_W-1:0] FPS_SAT = FPS_W'(1190000);

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] TARGET_FPS_RST      = CFG_DATA_W'(60);
	localparam logic [CFG_DATA_W-1:0] UPDATE_INTERVAL_RST = CFG_DATA_W'(60);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FPS      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = CFG_IDX_W'(1);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_RD_NEW,
		ST_DIV_EXP,
		ST_DIV_RATE,
		ST_DONE
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [TIME_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	// Ring index of base + offset, both below WINDOW
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] offset);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= (IDX_W + 1)'(WINDOW)) begin
			sum = sum - (IDX_W + 1)'(WINDOW);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

[hw/rtl/fprm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprm_if
// Valid/ready channels of the frame pacer: frame requests, results and
// register writes.
// ----------------------------------------------------------------------------
interface fprm_frame_if;
	logic                       valid;
	logic                       ready;
	logic [fprm_pkg::TIME_W-1:0] check_time_ms;
	logic [fprm_pkg::TIME_W-1:0] record_time_ms;

	modport source (output valid, check_time_ms, record_time_ms, input ready);
	modport sink   (input valid, check_time_ms, record_time_ms, output ready);
endinterface

interface fprm_result_if;
	logic                       valid;
	logic                       ready;
	logic [fprm_pkg::TIME_W-1:0] wait_ms;
	logic [fprm_pkg::FPS_W-1:0]  fps_tenths;
	logic                       fps_valid;

	modport source (output valid, wait_ms, fps_tenths, fps_valid, input ready);
	modport sink   (input valid, wait_ms, fps_tenths, fps_valid, output ready);
endinterface

interface fprm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fprm_pkg::CFG_IDX_W-1:0]  index;
	logic [fprm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/fprm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fprm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 120
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/fprm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprm_div
// Restoring divider, one quotient bit per cycle. Shared by the expected
// frame time and the rate measurement.
// ----------------------------------------------------------------------------
module fprm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fprm_pkg::div_req_t req,
	output fprm_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [fprm_pkg::STEP_W-1:0]    step_q;
	logic [fprm_pkg::NUM_W-1:0]     num_q;
	logic [fprm_pkg::TIME_W-1:0]    den_q;
	logic [fprm_pkg::TIME_W-1:0]    rem_q;
	logic [fprm_pkg::TIME_W:0]      trial;
	logic [fprm_pkg::TIME_W:0]      diff;
	logic                           qbit;
	logic [fprm_pkg::TIME_W-1:0]    rem_next;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial    = {rem_q, num_q[fprm_pkg::NUM_W-1]};
		diff     = trial - {1'b0, den_q};
		qbit     = (trial >= {1'b0, den_q});
		rem_next = qbit ? diff[fprm_pkg::TIME_W-1:0] : trial[fprm_pkg::TIME_W-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == fprm_pkg::STEP_W'(fprm_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[fprm_pkg::NUM_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

[hw/rtl/frame_pacer_with_rate_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacer_with_rate_meter
// Frame pacer over a sliding window of record timestamps, with a periodic
// frame rate measurement in tenths of a frame per second.
// ----------------------------------------------------------------------------
// Each frame request yields one result: the wait in ms that keeps frames at
// target_fps, and the last measured rate. The block handles one frame at a
// time. A frame makes two reads of the timestamp RAM, the second alongside
// one pass of the shared 22-step divider for the expected time, and on
// frames that measure the rate a second pass for the rate. The next request
// is taken while a result still waits in the output register. No clearing
// pass runs after reset; only stamps written since reset are used. The user
// must write registers on the cfg channel only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module frame_pacer_with_rate_meter (
	input logic                 clk,
	input logic                 arst_n,
	fprm_cfg_if.sink            cfg,
	fprm_frame_if.sink          frame,
	fprm_result_if.source       result
);

	fprm_pkg::state_t state_q, state_d;

	// Configuration
	logic [fprm_pkg::CFG_DATA_W-1:0] target_fps_q;
	logic [fprm_pkg::CFG_DATA_W-1:0] update_interval_q;

	// Window bookkeeping and rate state
	logic [fprm_pkg::IDX_W-1:0]  head_q;
	logic [fprm_pkg::CNT_W-1:0]  count_q;
	logic [7:0]                  frame_cnt_q;
	logic                        match_q;
	logic [fprm_pkg::FPS_W-1:0]  rate_q;
	logic                        rate_valid_q;

	// Frame payload and read data
	logic [fprm_pkg::TIME_W-1:0] check_q;
	logic [fprm_pkg::TIME_W-1:0] record_q;
	logic [fprm_pkg::TIME_W-1:0] oldest_q;
	logic [fprm_pkg::TIME_W-1:0] next_oldest_q;
	logic [fprm_pkg::TIME_W-1:0] wait_q;

	// Output register
	logic                        out_valid_q;
	logic [fprm_pkg::TIME_W-1:0] out_wait_q;
	logic [fprm_pkg::FPS_W-1:0]  out_fps_q;
	logic                        out_fps_valid_q;

	// RAM and divider hookup
	logic                        ram_we;
	logic [fprm_pkg::IDX_W-1:0]  ram_waddr;
	logic                        ram_re;
	logic [fprm_pkg::IDX_W-1:0]  ram_raddr;
	logic [fprm_pkg::TIME_W-1:0] ram_rdata;
	fprm_pkg::div_req_t          div_req;
	fprm_pkg::div_rsp_t          div_rsp;

	// Derived values
	logic                        frame_acc;
	logic                        full;
	logic [fprm_pkg::IDX_W-1:0]  head_inc;
	logic [fprm_pkg::IDX_W-1:0]  head_after;
	logic [fprm_pkg::IDX_W-1:0]  tail_idx;
	logic [7:0]                  frame_cnt_inc;
	logic [fprm_pkg::TIME_W-1:0] fps_den;
	logic [fprm_pkg::TIME_W-1:0] expected;
	logic [fprm_pkg::TIME_W-1:0] wait_diff;
	logic [fprm_pkg::TIME_W-1:0] wait_val;
	logic [fprm_pkg::TIME_W-1:0] span;
	logic                        measure;
	logic [fprm_pkg::NUM_W:0]    rate_inc;
	logic [fprm_pkg::TIME_W-1:0] rate_round;
	logic [fprm_pkg::FPS_W-1:0]  rate_sat;
	logic                        out_free;

	assign frame_acc = frame.valid && frame.ready;
	assign full      = (count_q == fprm_pkg::WINDOW_CNT);
	assign head_inc  = fprm_pkg::ring_add(head_q, fprm_pkg::IDX_W'(1));
	assign head_after = full ? head_inc : head_q;
	assign tail_idx  = fprm_pkg::ring_add(head_q, count_q[fprm_pkg::IDX_W-1:0]);
	assign frame_cnt_inc = frame_cnt_q + 8'd1;
	assign out_free  = !out_valid_q || result.ready;

	// Wait time from the expected elapsed time and the oldest stamp
	always_comb begin
		fps_den   = (target_fps_q == '0) ? fprm_pkg::TIME_W'(1)
			: fprm_pkg::TIME_W'(target_fps_q);
		expected  = fprm_pkg::TIME_W'(div_rsp.quot);
		wait_diff = expected - (check_q - oldest_q);
		wait_val  = '0;
		if (count_q != '0 && wait_diff != '0 && !wait_diff[fprm_pkg::TIME_W-1]) begin
			wait_val = wait_diff;
		end
	end

	// Rate measurement: round half up, then saturate
	always_comb begin
		span       = record_q - next_oldest_q;
		measure    = match_q && span != '0 &&
			(count_q == fprm_pkg::WINDOW_CNT || count_q == fprm_pkg::WINDOW_LAST_CNT);
		rate_inc   = {1'b0, div_rsp.quot} + (fprm_pkg::NUM_W + 1)'(1);
		rate_round = fprm_pkg::TIME_W'(rate_inc[fprm_pkg::NUM_W:1]);
		rate_sat   = (rate_round > fprm_pkg::TIME_W'(fprm_pkg::FPS_SAT)) ? fprm_pkg::FPS_SAT
			: rate_round[fprm_pkg::FPS_W-1:0];
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fprm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM and divider controls
	always_comb begin
		state_d     = state_q;
		frame.ready = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = head_q;
		ram_we      = 1'b0;
		ram_waddr   = full ? head_q : tail_idx;
		div_req.start = 1'b0;
		div_req.num = fprm_pkg::NUM_W'(count_q) * fprm_pkg::NUM_W'(fprm_pkg::MS_PER_S);
		div_req.den = fps_den;
		case (state_q)
			fprm_pkg::ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					ram_re  = 1'b1;
					state_d = fprm_pkg::ST_RD_OLD;
				end
			end
			fprm_pkg::ST_RD_OLD: begin
				ram_re        = 1'b1;
				ram_raddr     = head_after;
				div_req.start = 1'b1;
				state_d       = fprm_pkg::ST_RD_NEW;
			end
			fprm_pkg::ST_RD_NEW: begin
				state_d = fprm_pkg::ST_DIV_EXP;
			end
			fprm_pkg::ST_DIV_EXP: begin
				if (div_rsp.done) begin
					ram_we = 1'b1;
					if (measure) begin
						div_req.start = 1'b1;
						div_req.num   = fprm_pkg::NUM_W'(fprm_pkg::RATE_SCALE);
						div_req.den   = span;
						state_d       = fprm_pkg::ST_DIV_RATE;
					end else begin
						state_d = fprm_pkg::ST_DONE;
					end
				end
			end
			fprm_pkg::ST_DIV_RATE: begin
				if (div_rsp.done) begin
					state_d = fprm_pkg::ST_DONE;
				end
			end
			fprm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = fprm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fprm_pkg::ST_IDLE;
			end
		endcase
	end

	// Register writes; unknown indexes drop
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_fps_q      <= fprm_pkg::TARGET_FPS_RST;
			update_interval_q <= fprm_pkg::UPDATE_INTERVAL_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				fprm_pkg::REG_TARGET_FPS:      target_fps_q      <= cfg.data;
				fprm_pkg::REG_UPDATE_INTERVAL: update_interval_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Window, frame counter and rate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			frame_cnt_q  <= '0;
			match_q      <= 1'b0;
			rate_q       <= '0;
			rate_valid_q <= 1'b0;
		end else begin
			if (frame_acc) begin
				if (frame_cnt_inc == update_interval_q) begin
					frame_cnt_q <= '0;
					match_q     <= 1'b1;
				end else begin
					frame_cnt_q <= frame_cnt_inc;
					match_q     <= 1'b0;
				end
			end
			if (state_q == fprm_pkg::ST_DIV_EXP && div_rsp.done) begin
				if (full) begin
					head_q <= head_inc;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == fprm_pkg::ST_DIV_RATE && div_rsp.done) begin
				rate_q       <= rate_sat;
				rate_valid_q <= 1'b1;
			end
		end
	end

	// Frame payload, read data and wait capture
	always_ff @(posedge clk) begin
		if (frame_acc) begin
			check_q  <= frame.check_time_ms;
			record_q <= frame.record_time_ms;
		end
		if (state_q == fprm_pkg::ST_RD_OLD) begin
			oldest_q <= ram_rdata;
		end
		if (state_q == fprm_pkg::ST_RD_NEW) begin
			next_oldest_q <= ram_rdata;
		end
		if (state_q == fprm_pkg::ST_DIV_EXP && div_rsp.done) begin
			wait_q <= wait_val;
		end
	end

	// Output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == fprm_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fprm_pkg::ST_DONE && out_free) begin
			out_wait_q      <= wait_q;
			out_fps_q       <= rate_q;
			out_fps_valid_q <= rate_valid_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.wait_ms    = out_wait_q;
	assign result.fps_tenths = out_fps_q;
	assign result.fps_valid  = out_fps_valid_q;

	fprm_ram #(
		.WIDTH (fprm_pkg::TIME_W),
		.DEPTH (fprm_pkg::WINDOW)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (record_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fprm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Window fill never passes its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fprm_pkg::WINDOW_CNT)
		else $error("window count beyond depth");

	// Measured rate stays within saturation
	a_rate_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rate_q <= fprm_pkg::FPS_SAT)
		else $error("rate above saturation");

	// Once measured, the rate stays valid
	a_rate_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rate_valid_q |=> rate_valid_q)
		else $error("rate valid dropped");

	// An accepted request starts the oldest-stamp read
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc |=> state_q == fprm_pkg::ST_RD_OLD)
		else $error("accepted request did not start read");

	// Divider results arrive only while the sequencer waits for them
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == fprm_pkg::ST_DIV_EXP || state_q == fprm_pkg::ST_DIV_RATE))
		else $error("divider done outside a divide state");

endmodule
